// ----- rtl/cia_pkg.sv -----
package cia_pkg;

    // operand width default and result format
    localparam int OPERAND_WIDTH = 16;
    localparam int RESULT_WIDTH  = 32;
    // intermediate width wide enough for every sum at the widest operand
    localparam int WIDE_W        = 66;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // status codes
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_DIV_ZERO = 1'b1;

    // side information carried along the divider pipeline
    typedef struct packed {
        logic                    is_div;
        logic                    status;
        logic                    neg_re;
        logic                    neg_im;
        logic [RESULT_WIDTH-1:0] re;
        logic [RESULT_WIDTH-1:0] im;
    } t_side;

    // clamp a wide signed value to the signed result range
    function automatic logic [RESULT_WIDTH-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(signed'({1'b0, {(RESULT_WIDTH-1){1'b1}}}));
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            sat32 = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
        end else if (v < lo) begin
            sat32 = {1'b1, {(RESULT_WIDTH-1){1'b0}}};
        end else begin
            sat32 = v[RESULT_WIDTH-1:0];
        end
    endfunction

endpackage

// ----- rtl/cia_if.sv -----
// input word: operation and two complex operands
interface cia_in_if #(
    parameter int W = cia_pkg::OPERAND_WIDTH
);
    logic         valid;
    logic         ready;
    logic [1:0]   operation;
    logic [W-1:0] a_real;
    logic [W-1:0] a_imag;
    logic [W-1:0] b_real;
    logic [W-1:0] b_imag;

    modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// output word: complex result and status
interface cia_out_if;
    logic                              valid;
    logic                              ready;
    logic [cia_pkg::RESULT_WIDTH-1:0]  result_real;
    logic [cia_pkg::RESULT_WIDTH-1:0]  result_imag;
    logic                              status;

    modport source (output valid, result_real, result_imag, status, input ready);
    modport sink   (input valid, result_real, result_imag, status, output ready);
endinterface

// ----- rtl/cia_div_step.sv -----
// one restoring division step for both parts, shared divisor
module cia_div_step #(
    parameter int DW = 33,
    parameter int QW = 18
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  cia_pkg::t_side         i_side,
    input  logic [DW-1:0]          i_den,
    input  logic [DW-1:0]          i_rem_re,
    input  logic [DW-1:0]          i_rem_im,
    input  logic [QW-1:0]          i_dq_re,
    input  logic [QW-1:0]          i_dq_im,
    output logic                   o_valid,
    output cia_pkg::t_side         o_side,
    output logic [DW-1:0]          o_den,
    output logic [DW-1:0]          o_rem_re,
    output logic [DW-1:0]          o_rem_im,
    output logic [QW-1:0]          o_dq_re,
    output logic [QW-1:0]          o_dq_im
);
    logic [DW:0]   n_rem2_re;
    logic [DW:0]   n_rem2_im;
    logic          n_ge_re;
    logic          n_ge_im;
    logic [DW-1:0] n_rem_re;
    logic [DW-1:0] n_rem_im;
    logic [DW:0]   n_rem_re_w;
    logic [DW:0]   n_rem_im_w;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        n_rem2_re  = {i_rem_re, i_dq_re[QW-1]};
        n_rem2_im  = {i_rem_im, i_dq_im[QW-1]};
        n_ge_re    = n_rem2_re >= {1'b0, i_den};
        n_ge_im    = n_rem2_im >= {1'b0, i_den};
        n_rem_re_w = n_ge_re ? (n_rem2_re - {1'b0, i_den}) : n_rem2_re;
        n_rem_im_w = n_ge_im ? (n_rem2_im - {1'b0, i_den}) : n_rem2_im;
        n_rem_re   = n_rem_re_w[DW-1:0];
        n_rem_im   = n_rem_im_w[DW-1:0];
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side   <= i_side;
            o_den    <= i_den;
            o_rem_re <= n_rem_re;
            o_rem_im <= n_rem_im;
            o_dq_re  <= {i_dq_re[QW-2:0], n_ge_re};
            o_dq_im  <= {i_dq_im[QW-2:0], n_ge_im};
        end
    end
endmodule

// ----- rtl/complex_integer_alu.sv -----
// Complex integer ALU: add, subtract, multiply or divide two complex operands with
// OPERAND_WIDTH-bit signed parts, giving 32-bit signed parts that saturate at the range
// limits. Division returns floor(N/D + 1/2) per part, exact, halves rounded up; a zero
// divisor gives status 1 and zero parts. The block accepts one word every cycle while the
// output word is not held, and each word passes through registers for the multipliers,
// the sums and the dividends, one restoring step per quotient bit (OPERAND_WIDTH + 2 of
// them) and the output register.
// All stages hold together while the output word waits to be taken.
module complex_integer_alu #(
    parameter int OPERAND_WIDTH = cia_pkg::OPERAND_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cia_in_if.sink   i_in,
    cia_out_if.source o_out
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 1;
    localparam int MW = 2 * W + 2;
    localparam int QW = W + 2;
    localparam int XW = cia_pkg::WIDE_W;

    logic en;

    // stage 1: products
    logic              r1_valid;
    logic [1:0]        r1_op;
    logic              r1_bz;
    logic signed [W-1:0]  r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [PW-1:0] r1_rr, r1_ii, r1_ri, r1_ir, r1_bbr, r1_bbi;

    // stage 2: sums
    logic              r2_valid;
    cia_pkg::t_side    r2_side;
    logic [DW-1:0]     r2_d;
    logic signed [PW:0] r2_nr, r2_ni;
    cia_pkg::t_side    n2_side;
    logic signed [PW:0] n2_mre, n2_mim;
    logic signed [W:0]  n2_are, n2_aim, n2_sre, n2_sim;

    // stage 3 into the divider chain
    logic signed [MW:0] n3_num_re, n3_num_im;
    logic [MW:0]        n3_mag_re_w, n3_mag_im_w;
    cia_pkg::t_side     n3_side;
    logic [DW:0]        n3_den_w;

    logic           c_valid [QW+1];
    cia_pkg::t_side c_side  [QW+1];
    logic [DW-1:0]  c_den   [QW+1];
    logic [DW-1:0]  c_rem_re[QW+1];
    logic [DW-1:0]  c_rem_im[QW+1];
    logic [QW-1:0]  c_dq_re [QW+1];
    logic [QW-1:0]  c_dq_im [QW+1];

    // output stage
    logic                r_out_valid;
    logic [31:0]         r_out_re, r_out_im;
    logic                r_out_status;
    logic signed [QW+1:0] n_q_re, n_q_im, n_v_re, n_v_im;
    logic [31:0]         n_out_re, n_out_im;

    // the whole pipeline moves unless the output word is held
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op  <= i_in.operation;
            r1_bz  <= (i_in.b_real == '0) && (i_in.b_imag == '0);
            r1_ar  <= $signed(i_in.a_real);
            r1_ai  <= $signed(i_in.a_imag);
            r1_br  <= $signed(i_in.b_real);
            r1_bi  <= $signed(i_in.b_imag);
            r1_rr  <= $signed(i_in.a_real) * $signed(i_in.b_real);
            r1_ii  <= $signed(i_in.a_imag) * $signed(i_in.b_imag);
            r1_ri  <= $signed(i_in.a_real) * $signed(i_in.b_imag);
            r1_ir  <= $signed(i_in.a_imag) * $signed(i_in.b_real);
            r1_bbr <= $signed(i_in.b_real) * $signed(i_in.b_real);
            r1_bbi <= $signed(i_in.b_imag) * $signed(i_in.b_imag);
        end
    end

    // stage 2: add, subtract, multiply results and division terms
    always_comb begin
        n2_are = r1_ar + r1_br;
        n2_aim = r1_ai + r1_bi;
        n2_sre = r1_ar - r1_br;
        n2_sim = r1_ai - r1_bi;
        n2_mre = r1_rr - r1_ii;
        n2_mim = r1_ri + r1_ir;
        n2_side        = '0;
        n2_side.status = cia_pkg::ST_OK;
        unique case (r1_op)
            cia_pkg::OP_ADD: begin
                n2_side.re = cia_pkg::sat32(XW'(n2_are));
                n2_side.im = cia_pkg::sat32(XW'(n2_aim));
            end
            cia_pkg::OP_SUB: begin
                n2_side.re = cia_pkg::sat32(XW'(n2_sre));
                n2_side.im = cia_pkg::sat32(XW'(n2_sim));
            end
            cia_pkg::OP_MUL: begin
                n2_side.re = cia_pkg::sat32(XW'(n2_mre));
                n2_side.im = cia_pkg::sat32(XW'(n2_mim));
            end
            default: begin
                n2_side.is_div = !r1_bz;
                n2_side.status = r1_bz ? cia_pkg::ST_DIV_ZERO : cia_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side <= n2_side;
            r2_d    <= r1_bbr + r1_bbi;
            r2_nr   <= r1_rr + r1_ii;
            r2_ni   <= r1_ir - r1_ri;
        end
    end

    // stage 3: dividends 2N + D as sign and magnitude, divisor 2D
    always_comb begin
        n3_num_re   = $signed({r2_nr, 1'b0}) + $signed({2'b00, r2_d});
        n3_num_im   = $signed({r2_ni, 1'b0}) + $signed({2'b00, r2_d});
        n3_mag_re_w = n3_num_re[MW] ? 
                      ($unsigned(-n3_num_re)) : $unsigned(n3_num_re);
        n3_mag_im_w = n3_num_im[MW] ? 
                      ($unsigned(-n3_num_im)) : $unsigned(n3_num_im);
        n3_den_w    = {r2_d, 1'b0};
        n3_side         = r2_side;
        n3_side.neg_re  = n3_num_re[MW];
        n3_side.neg_im  = n3_num_im[MW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_valid[0] <= 1'b0;
        end else if (en) begin
            c_valid[0] <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            c_side[0]   <= n3_side;
            c_den[0]    <= n3_den_w[DW-1:0];
            c_rem_re[0] <= DW'(n3_mag_re_w[MW-1:QW]);
            c_rem_im[0] <= DW'(n3_mag_im_w[MW-1:QW]);
            c_dq_re[0]  <= n3_mag_re_w[QW-1:0];
            c_dq_im[0]  <= n3_mag_im_w[QW-1:0];
        end
    end

    // divider chain, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        cia_div_step #(
            .DW (DW),
            .QW (QW)
        ) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (c_valid[k]),
            .i_side   (c_side[k]),
            .i_den    (c_den[k]),
            .i_rem_re (c_rem_re[k]),
            .i_rem_im (c_rem_im[k]),
            .i_dq_re  (c_dq_re[k]),
            .i_dq_im  (c_dq_im[k]),
            .o_valid  (c_valid[k+1]),
            .o_side   (c_side[k+1]),
            .o_den    (c_den[k+1]),
            .o_rem_re (c_rem_re[k+1]),
            .o_rem_im (c_rem_im[k+1]),
            .o_dq_re  (c_dq_re[k+1]),
            .o_dq_im  (c_dq_im[k+1])
        );
    end

    // floor for negative dividends, then clamp
    always_comb begin
        n_q_re = $signed({2'b00, c_dq_re[QW]});
        n_q_im = $signed({2'b00, c_dq_im[QW]});
        n_v_re = c_side[QW].neg_re ?
                 (-n_q_re - $signed({{(QW+1){1'b0}}, (c_rem_re[QW] != '0)})) : n_q_re;
        n_v_im = c_side[QW].neg_im ?
                 (-n_q_im - $signed({{(QW+1){1'b0}}, (c_rem_im[QW] != '0)})) : n_q_im;
        if (c_side[QW].is_div) begin
            n_out_re = cia_pkg::sat32(XW'(n_v_re));
            n_out_im = cia_pkg::sat32(XW'(n_v_im));
        end else begin
            n_out_re = c_side[QW].re;
            n_out_im = c_side[QW].im;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_re     <= n_out_re;
            r_out_im     <= n_out_im;
            r_out_status <= c_side[QW].status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_real = r_out_re;
    assign o_out.result_imag = r_out_im;
    assign o_out.status      = r_out_status;
endmodule
